[sv/tmc_pkg.sv]
// Shared types, constants and the arctangent table for the triangle measure core.
package tmc_pkg;

	localparam int SIDE_W  = 16;
	localparam int PERIM_W = 18;
	localparam int AREA_W  = 23;
	localparam int ANGLE_W = 16;
	localparam int SQ_W    = 2 * SIDE_W;      // one squared side
	localparam int XL_W    = SQ_W + 2;        // signed u*u + v*v - s*s
	localparam int ROOT_W  = 37;              // floor(sqrt(P)), P below 2^72
	localparam int REM_W   = 74;              // radicand / remainder width
	localparam int CV_W    = 40;              // CORDIC vector width
	localparam int Z_W     = 26;              // angle accumulator, deg * 65536
	localparam int CORDIC_STEPS = 23;
	localparam int AREA_SHIFT   = 10;

	localparam logic signed [Z_W-1:0] DEG90_Q16  = 26'sd5898240;
	localparam logic signed [Z_W-1:0] DEG180_Q16 = 26'sd11796480;

	localparam logic [1:0] CLASS_NONE  = 2'd0;
	localparam logic [1:0] CLASS_RIGHT = 2'd1;
	localparam logic [1:0] CLASS_EQUI  = 2'd2;
	localparam logic [1:0] CLASS_ISO   = 2'd3;

	typedef struct packed {
		logic [SIDE_W-1:0] side_a;
		logic [SIDE_W-1:0] side_b;
		logic [SIDE_W-1:0] side_c;
	} sides_t;

	typedef struct packed {
		logic               valid_res;
		logic [PERIM_W-1:0] perimeter;
		logic [AREA_W-1:0]  area;
		logic [ANGLE_W-1:0] angle_a;
		logic [ANGLE_W-1:0] angle_b;
		logic [ANGLE_W-1:0] angle_c;
		logic [1:0]         shape_class;
	} result_t;

	// data that rides alongside the root extraction
	typedef struct packed {
		logic                     valid_res;
		logic [PERIM_W-1:0]       perimeter;
		logic [1:0]               shape_class;
		logic signed [XL_W-1:0]   x_a;
		logic signed [XL_W-1:0]   x_b;
		logic signed [XL_W-1:0]   x_c;
	} side_info_t;

	// atan(2^-i) in degrees * 65536, rounded to nearest
	function automatic logic signed [Z_W-1:0] atan_q16(input int i);
		logic signed [Z_W-1:0] t;
		begin
			case (i)
				0: t = 26'sd2949120;
				1: t = 26'sd1740967;
				2: t = 26'sd919879;
				3: t = 26'sd466945;
				4: t = 26'sd234379;
				5: t = 26'sd117304;
				6: t = 26'sd58666;
				7: t = 26'sd29335;
				8: t = 26'sd14668;
				9: t = 26'sd7334;
				10: t = 26'sd3667;
				11: t = 26'sd1833;
				12: t = 26'sd917;
				13: t = 26'sd458;
				14: t = 26'sd229;
				15: t = 26'sd115;
				16: t = 26'sd57;
				17: t = 26'sd29;
				18: t = 26'sd14;
				19: t = 26'sd7;
				20: t = 26'sd4;
				21: t = 26'sd2;
				22: t = 26'sd1;
				default: t = '0;
			endcase
			return t;
		end
	endfunction

endpackage

[sv/triangle_measure_classify_core.sv]
// Triangle measure/classify core: perimeter, Heron area, three angles and shape class.
// A beat accepted with start high passes 4 front stages, 37 root stages (one bit each),
// 1 pre-rotation stage, 23 CORDIC stages and 1 output register, and comes out with done
// high. Throughput: one beat per cycle, every cycle.
// busy is always low; the receiver cannot stall, so the pipeline never holds.
// Reset (arst_n low, async) clears the per-stage valid bits only; data is not reset.
module triangle_measure_classify_core (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  tmc_pkg::sides_t sides,
	output logic            done,
	output tmc_pkg::result_t result
);

	localparam int SQRT_STAGES = tmc_pkg::ROOT_W;
	localparam int STEPS = tmc_pkg::CORDIC_STEPS;

	// no back-pressure anywhere: every cycle may take a beat
	assign busy = 1'b0;

	// ------------------------------------------------------------------
	// Stage 1: Heron factors, squares, validity and equality flags
	// ------------------------------------------------------------------
	logic        vld_s1;
	logic [17:0] p1_s1;
	logic [16:0] p2_s1, p3_s1, p4_s1;
	logic [31:0] aa_s1, bb_s1, cc_s1;
	logic        ok_s1, ab_eq_s1, ac_eq_s1, bc_eq_s1;

	logic [16:0] ab_sum, ac_sum, bc_sum;
	assign ab_sum = 17'(sides.side_a) + 17'(sides.side_b);
	assign ac_sum = 17'(sides.side_a) + 17'(sides.side_c);
	assign bc_sum = 17'(sides.side_b) + 17'(sides.side_c);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s1 <= 1'b0;
		else         vld_s1 <= start & ~busy;
	end

	always_ff @(posedge clk) begin
		p1_s1 <= 18'(ab_sum) + 18'(sides.side_c);
		// these wrap on a broken triangle; the result is zeroed at the end anyway
		p2_s1 <= bc_sum - 17'(sides.side_a);
		p3_s1 <= ac_sum - 17'(sides.side_b);
		p4_s1 <= ab_sum - 17'(sides.side_c);
		aa_s1 <= sides.side_a * sides.side_a;
		bb_s1 <= sides.side_b * sides.side_b;
		cc_s1 <= sides.side_c * sides.side_c;
		ok_s1 <= (sides.side_a != '0) && (sides.side_b != '0) && (sides.side_c != '0)
			&& (ab_sum > 17'(sides.side_c)) && (ac_sum > 17'(sides.side_b))
			&& (bc_sum > 17'(sides.side_a));
		ab_eq_s1 <= sides.side_a == sides.side_b;
		ac_eq_s1 <= sides.side_a == sides.side_c;
		bc_eq_s1 <= sides.side_b == sides.side_c;
	end

	// ------------------------------------------------------------------
	// Stage 2: pair products, law-of-cosines numerators, class
	// ------------------------------------------------------------------
	logic        vld_s2;
	logic [34:0] m1_s2;
	logic [33:0] m2_s2;
	tmc_pkg::side_info_t info_s2;

	logic [32:0] ab2, ac2, bc2;
	logic [1:0]  cls;
	assign ab2 = 33'(aa_s1) + 33'(bb_s1);
	assign ac2 = 33'(aa_s1) + 33'(cc_s1);
	assign bc2 = 33'(bb_s1) + 33'(cc_s1);

	always_comb begin
		if (ab2 == 33'(cc_s1) || ac2 == 33'(bb_s1) || bc2 == 33'(aa_s1))
			cls = tmc_pkg::CLASS_RIGHT;
		else if (ab_eq_s1 && ac_eq_s1)
			cls = tmc_pkg::CLASS_EQUI;
		else if (ab_eq_s1 || ac_eq_s1 || bc_eq_s1)
			cls = tmc_pkg::CLASS_ISO;
		else
			cls = tmc_pkg::CLASS_NONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s2 <= 1'b0;
		else         vld_s2 <= vld_s1;
	end

	always_ff @(posedge clk) begin
		m1_s2 <= 35'(p1_s1) * 35'(p2_s1);
		m2_s2 <= 34'(p3_s1) * 34'(p4_s1);
		info_s2.valid_res   <= ok_s1;
		info_s2.perimeter   <= p1_s1;
		info_s2.shape_class <= cls;
		info_s2.x_a <= $signed({1'b0, bc2}) - $signed({2'b0, aa_s1});
		info_s2.x_b <= $signed({1'b0, ac2}) - $signed({2'b0, bb_s1});
		info_s2.x_c <= $signed({1'b0, ab2}) - $signed({2'b0, cc_s1});
	end

	// ------------------------------------------------------------------
	// Stage 3: 35x34 product cut in two 35x17 partial products
	// ------------------------------------------------------------------
	logic        vld_s3;
	logic [51:0] pp_lo_s3, pp_hi_s3;
	tmc_pkg::side_info_t info_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s3 <= 1'b0;
		else         vld_s3 <= vld_s2;
	end

	always_ff @(posedge clk) begin
		pp_lo_s3 <= 52'(m1_s2) * 52'(m2_s2[16:0]);
		pp_hi_s3 <= 52'(m1_s2) * 52'(m2_s2[33:17]);
		info_s3  <= info_s2;
	end

	// ------------------------------------------------------------------
	// Stage 4: radicand P = 16 K^2 (raw units)
	// ------------------------------------------------------------------
	logic                        vld_s4;
	logic [tmc_pkg::REM_W-1:0]   rad_s4;
	tmc_pkg::side_info_t         info_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) vld_s4 <= 1'b0;
		else         vld_s4 <= vld_s3;
	end

	always_ff @(posedge clk) begin
		rad_s4  <= tmc_pkg::REM_W'(pp_lo_s3) + (tmc_pkg::REM_W'(pp_hi_s3) << 17);
		info_s4 <= info_s3;
	end

	// ------------------------------------------------------------------
	// Root stages: restoring square root, one result bit per stage, MSB first
	// ------------------------------------------------------------------
	logic                       sq_vld_s  [0:SQRT_STAGES];
	logic [tmc_pkg::REM_W-1:0]  sq_rem_s  [0:SQRT_STAGES];
	logic [tmc_pkg::ROOT_W-1:0] sq_root_s [0:SQRT_STAGES];
	tmc_pkg::side_info_t        sq_info_s [0:SQRT_STAGES];

	assign sq_vld_s[0]  = vld_s4;
	assign sq_rem_s[0]  = rad_s4;
	assign sq_root_s[0] = '0;
	assign sq_info_s[0] = info_s4;

	for (genvar j = 0; j < SQRT_STAGES; j++) begin : g_sqrt
		localparam int K = SQRT_STAGES - 1 - j;
		logic [tmc_pkg::REM_W-1:0] trial;
		// (r + 2^K)^2 - r^2
		assign trial = (tmc_pkg::REM_W'(sq_root_s[j]) << (K + 1))
			+ (tmc_pkg::REM_W'(1) << (2 * K));

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) sq_vld_s[j+1] <= 1'b0;
			else         sq_vld_s[j+1] <= sq_vld_s[j];
		end

		always_ff @(posedge clk) begin
			if (sq_rem_s[j] >= trial) begin
				sq_rem_s[j+1]  <= sq_rem_s[j] - trial;
				sq_root_s[j+1] <= sq_root_s[j] | (tmc_pkg::ROOT_W'(1) << K);
			end else begin
				sq_rem_s[j+1]  <= sq_rem_s[j];
				sq_root_s[j+1] <= sq_root_s[j];
			end
			sq_info_s[j+1] <= sq_info_s[j];
		end
	end

	// ------------------------------------------------------------------
	// Pre-rotation: a negative X turns the vector by -90 deg, z starts at 90
	// ------------------------------------------------------------------
	logic                      cv_vld_s [0:STEPS];
	logic signed [tmc_pkg::CV_W-1:0] cx_s [0:STEPS][0:2];
	logic signed [tmc_pkg::CV_W-1:0] cy_s [0:STEPS][0:2];
	logic signed [tmc_pkg::Z_W-1:0]  cz_s [0:STEPS][0:2];
	logic [tmc_pkg::PERIM_W-1:0] cv_perim_s [0:STEPS];
	logic [tmc_pkg::AREA_W-1:0]  cv_area_s  [0:STEPS];
	logic [1:0]                  cv_cls_s   [0:STEPS];
	logic                        cv_ok_s    [0:STEPS];

	logic signed [tmc_pkg::XL_W-1:0] xin [0:2];
	logic signed [tmc_pkg::CV_W-1:0] yin;
	assign xin[0] = sq_info_s[SQRT_STAGES].x_a;
	assign xin[1] = sq_info_s[SQRT_STAGES].x_b;
	assign xin[2] = sq_info_s[SQRT_STAGES].x_c;
	assign yin = $signed({3'b0, sq_root_s[SQRT_STAGES]});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) cv_vld_s[0] <= 1'b0;
		else         cv_vld_s[0] <= sq_vld_s[SQRT_STAGES];
	end

	always_ff @(posedge clk) begin
		for (int l = 0; l < 3; l++) begin
			if (xin[l] < 0) begin
				cx_s[0][l] <= yin;
				cy_s[0][l] <= -tmc_pkg::CV_W'(xin[l]);
				cz_s[0][l] <= tmc_pkg::DEG90_Q16;
			end else begin
				cx_s[0][l] <= tmc_pkg::CV_W'(xin[l]);
				cy_s[0][l] <= yin;
				cz_s[0][l] <= '0;
			end
		end
		cv_perim_s[0] <= sq_info_s[SQRT_STAGES].perimeter;
		cv_area_s[0]  <= tmc_pkg::AREA_W'(sq_root_s[SQRT_STAGES] >> tmc_pkg::AREA_SHIFT);
		cv_cls_s[0]   <= sq_info_s[SQRT_STAGES].shape_class;
		cv_ok_s[0]    <= sq_info_s[SQRT_STAGES].valid_res;
	end

	// ------------------------------------------------------------------
	// CORDIC vectoring, one micro-rotation per stage, three lanes
	// ------------------------------------------------------------------
	for (genvar i = 0; i < STEPS; i++) begin : g_cordic
		localparam logic signed [tmc_pkg::Z_W-1:0] T = tmc_pkg::atan_q16(i);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) cv_vld_s[i+1] <= 1'b0;
			else         cv_vld_s[i+1] <= cv_vld_s[i];
		end

		always_ff @(posedge clk) begin
			for (int l = 0; l < 3; l++) begin
				if (cy_s[i][l] >= 0) begin
					cx_s[i+1][l] <= cx_s[i][l] + (cy_s[i][l] >>> i);
					cy_s[i+1][l] <= cy_s[i][l] - (cx_s[i][l] >>> i);
					cz_s[i+1][l] <= cz_s[i][l] + T;
				end else begin
					cx_s[i+1][l] <= cx_s[i][l] - (cy_s[i][l] >>> i);
					cy_s[i+1][l] <= cy_s[i][l] + (cx_s[i][l] >>> i);
					cz_s[i+1][l] <= cz_s[i][l] - T;
				end
			end
			cv_perim_s[i+1] <= cv_perim_s[i];
			cv_area_s[i+1]  <= cv_area_s[i];
			cv_cls_s[i+1]   <= cv_cls_s[i];
			cv_ok_s[i+1]    <= cv_ok_s[i];
		end
	end

	// ------------------------------------------------------------------
	// Output register: clamp to [0, 180] deg, round to Q8.8, zero if invalid
	// ------------------------------------------------------------------
	logic [tmc_pkg::ANGLE_W-1:0] ang [0:2];

	always_comb begin
		for (int l = 0; l < 3; l++) begin
			logic [23:0] zc;
			logic [24:0] zr;
			if (cz_s[STEPS][l] < 0)
				zc = '0;
			else if (cz_s[STEPS][l] > tmc_pkg::DEG180_Q16)
				zc = 24'(tmc_pkg::DEG180_Q16);
			else
				zc = 24'(cz_s[STEPS][l]);
			zr = 25'(zc) + 25'd128;
			ang[l] = tmc_pkg::ANGLE_W'(zr >> 8);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done <= 1'b0;
		else         done <= cv_vld_s[STEPS];
	end

	always_ff @(posedge clk) begin
		if (cv_ok_s[STEPS]) begin
			result.valid_res   <= 1'b1;
			result.perimeter   <= cv_perim_s[STEPS];
			result.area        <= cv_area_s[STEPS];
			result.angle_a     <= ang[0];
			result.angle_b     <= ang[1];
			result.angle_c     <= ang[2];
			result.shape_class <= cv_cls_s[STEPS];
		end else begin
			result <= '0;
		end
	end

	// ------------------------------------------------------------------
	// Assertions
	// ------------------------------------------------------------------
	a_no_busy: assert property (@(posedge clk) disable iff (!arst_n) !busy)
		else $error("core signalled busy");

	a_invalid_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && !result.valid_res |-> result.perimeter == '0 && result.area == '0
			&& result.shape_class == tmc_pkg::CLASS_NONE)
		else $error("broken triangle beat carries nonzero fields");

	a_angle_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> result.angle_a <= 16'd46080 && result.angle_b <= 16'd46080
			&& result.angle_c <= 16'd46080)
		else $error("angle beyond 180 degrees");

	a_valid_perim: assert property (@(posedge clk) disable iff (!arst_n)
		done && result.valid_res |-> result.perimeter != '0)
		else $error("valid triangle with zero perimeter");

endmodule

[tb/tb_triangle_measure_classify_core.sv]
// Testbench for the triangle measure/classify core: directed and random triangles, scoreboarded.
`timescale 1ns / 1ps

// Holds the expected triangle results in order and checks each result beat.
class triangle_scoreboard;
	tmc_pkg::result_t pending_results[$];
	int error_count;

	function new();
		error_count = 0;
	endfunction

	// floor(sqrt(v)) for v below 2^72, one bit at a time
	static function automatic logic [36:0] isqrt(input logic [79:0] v);
		logic [36:0] root;
		logic [36:0] cand;
		root = '0;
		for (int bit_idx = 36; bit_idx >= 0; bit_idx--) begin
			cand = root | (37'd1 << bit_idx);
			if ({43'd0, cand} * {43'd0, cand} <= v)
				root = cand;
		end
		return root;
	endfunction

	// CORDIC vectoring atan2(y, x) in degrees, rounded to Q8.8
	static function automatic logic [15:0] vector_angle(input longint x0, input longint y0);
		longint x, y, z, xs, ys, tmp;
		longint steps[23];
		logic [63:0] zr;
		steps = '{2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
			14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1};
		x = x0;
		y = y0;
		z = 0;
		if (x < 0) begin
			tmp = x;
			x = y;
			y = -tmp;
			z = 5898240;
		end
		for (int i = 0; i < 23; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + steps[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - steps[i];
			end
		end
		if (z < 0)
			z = 0;
		if (z > 11796480)
			z = 11796480;
		zr = (z + 128) >> 8;
		return zr[15:0];
	endfunction

	static function automatic tmc_pkg::result_t measure(input tmc_pkg::sides_t s);
		tmc_pkg::result_t r;
		longint a, b, c, aa, bb, cc;
		logic [79:0] prod;
		logic [36:0] root;
		a = s.side_a;
		b = s.side_b;
		c = s.side_c;
		r = '0;
		if (a == 0 || b == 0 || c == 0 || a + b <= c || a + c <= b || b + c <= a)
			return r;
		aa = a * a;
		bb = b * b;
		cc = c * c;
		prod = 80'((a + b + c) * (b + c - a)) * 80'((a + c - b) * (a + b - c));
		root = isqrt(prod);
		r.valid_res = 1'b1;
		r.perimeter = 18'(a + b + c);
		r.area = 23'(root >> tmc_pkg::AREA_SHIFT);
		r.angle_a = vector_angle(bb + cc - aa, longint'(root));
		r.angle_b = vector_angle(aa + cc - bb, longint'(root));
		r.angle_c = vector_angle(aa + bb - cc, longint'(root));
		if (aa + bb == cc || aa + cc == bb || bb + cc == aa)
			r.shape_class = tmc_pkg::CLASS_RIGHT;
		else if (a == b && a == c)
			r.shape_class = tmc_pkg::CLASS_EQUI;
		else if (a == b || a == c || b == c)
			r.shape_class = tmc_pkg::CLASS_ISO;
		else
			r.shape_class = tmc_pkg::CLASS_NONE;
		return r;
	endfunction

	function void note_sides(input tmc_pkg::sides_t s);
		pending_results.push_back(measure(s));
	endfunction

	function void check_result(input tmc_pkg::result_t got);
		tmc_pkg::result_t want;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result beat, expected none, actual %h", $time, got);
			error_count++;
			return;
		end
		want = pending_results.pop_front();
		if (got.valid_res !== want.valid_res) begin
			$display("%0t: valid_res expected %0d actual %0d", $time, want.valid_res,
				got.valid_res);
			error_count++;
		end
		if (got.perimeter !== want.perimeter) begin
			$display("%0t: perimeter expected %0d actual %0d", $time, want.perimeter,
				got.perimeter);
			error_count++;
		end
		if (got.area !== want.area) begin
			$display("%0t: area expected %0d actual %0d", $time, want.area, got.area);
			error_count++;
		end
		if (got.angle_a !== want.angle_a) begin
			$display("%0t: angle_a expected %0d actual %0d", $time, want.angle_a, got.angle_a);
			error_count++;
		end
		if (got.angle_b !== want.angle_b) begin
			$display("%0t: angle_b expected %0d actual %0d", $time, want.angle_b, got.angle_b);
			error_count++;
		end
		if (got.angle_c !== want.angle_c) begin
			$display("%0t: angle_c expected %0d actual %0d", $time, want.angle_c, got.angle_c);
			error_count++;
		end
		if (got.shape_class !== want.shape_class) begin
			$display("%0t: shape_class expected %0d actual %0d", $time, want.shape_class,
				got.shape_class);
			error_count++;
		end
	endfunction
endclass

module tb_triangle_measure_classify_core;

	localparam int RANDOM_BEATS = 1130;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 100;

	logic             clk;
	logic             arst_n;
	logic             start;
	logic             busy;
	tmc_pkg::sides_t  sides;
	logic             done;
	tmc_pkg::result_t result;

	triangle_scoreboard sb;
	int cycle_count;

	triangle_measure_classify_core u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.sides  (sides),
		.done   (done),
		.result (result)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// result beats last one cycle and cannot be held off: check every done edge
	always @(posedge clk) begin
		if (arst_n && done === 1'b1)
			sb.check_result(result);
	end

	// watchdog: generous bound over 1155 beats plus idle bursts and pipeline depth
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// one command beat; start stays high across back-to-back beats
	task automatic send_sides(input tmc_pkg::sides_t s, input bit allow_gap);
		int gap;
		if (allow_gap && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 5);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		sides <= s;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		sb.note_sides(s);
	endtask

	function automatic tmc_pkg::sides_t mk(input int a, input int b, input int c);
		tmc_pkg::sides_t s;
		s.side_a = 16'(a);
		s.side_b = 16'(b);
		s.side_c = 16'(c);
		return s;
	endfunction

	// mostly valid triangles: two random sides, third inside the open interval
	function automatic tmc_pkg::sides_t random_sides();
		tmc_pkg::sides_t s;
		int a, b, lo, hi, c, k, pick;
		pick = $urandom_range(0, 99);
		if (pick < 10) begin
			s = mk($urandom_range(0, 65535), $urandom_range(0, 65535),
				$urandom_range(0, 65535));
		end else if (pick < 18) begin
			// scaled 3-4-5 right triangle, random rotation
			k = $urandom_range(1, 13107);
			case ($urandom_range(0, 2))
				0: s = mk(3 * k, 4 * k, 5 * k);
				1: s = mk(5 * k, 3 * k, 4 * k);
				default: s = mk(4 * k, 5 * k, 3 * k);
			endcase
		end else if (pick < 26) begin
			a = $urandom_range(1, 65535);
			b = $urandom_range((a + 1) / 2, 65535);
			if (b == 0) b = 1;
			case ($urandom_range(0, 3))
				0: s = mk(a, a, a);
				1: s = mk(a, a, b);
				2: s = mk(b, a, a);
				default: s = mk(a, b, a);
			endcase
		end else begin
			a = (pick < 60) ? $urandom_range(1, 1023) : $urandom_range(1, 65535);
			b = (pick < 60) ? $urandom_range(1, 1023) : $urandom_range(1, 65535);
			lo = (a > b ? a - b : b - a) + 1;
			hi = a + b - 1;
			if (hi > 65535) hi = 65535;
			c = (lo <= hi) ? $urandom_range(lo, hi) : $urandom_range(0, 65535);
			s = mk(a, b, c);
		end
		return s;
	endfunction

	initial begin
		tmc_pkg::sides_t directed[$];
		sb = new();
		cycle_count = 0;
		arst_n = 1'b0;
		start = 1'b0;
		sides = '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes, every class, degenerate and zero sides
		directed = '{mk(0, 0, 0), mk(0, 5, 5), mk(5, 0, 5), mk(5, 5, 0),
			mk(65535, 65535, 65535), mk(1, 1, 1), mk(3, 4, 5), mk(5, 3, 4),
			mk(4, 5, 3), mk(768, 1024, 1280), mk(256, 256, 300), mk(300, 256, 256),
			mk(256, 300, 256), mk(100, 200, 300), mk(1, 2, 3), mk(65535, 65535, 1),
			mk(1, 65535, 65535), mk(65535, 1, 65535), mk(65535, 32768, 32768),
			mk(65535, 32767, 32769), mk(1000, 1500, 2000), mk(2, 3, 4),
			mk(39321, 52428, 65535), mk(500, 700, 1100), mk(43690, 21845, 65534)};
		foreach (directed[i])
			send_sides(directed[i], 1'b1);

		for (int n = 0; n < RANDOM_BEATS; n++)
			send_sides(random_sides(), n < RANDOM_BEATS - 150);
		start <= 1'b0;

		while (sb.pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (sb.error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
